### rtl/swdt_pkg.sv
`default_nettype none
package swdt_pkg;

  localparam int HIST_DEPTH       = 240;
  localparam int MINUTES_PER_HOUR = 60;

  localparam int TEMP_W  = 15;
  localparam int ENTRY_W = TEMP_W + 1;
  localparam int TREND_W = 16;
  localparam int DUTY_W  = 6;
  localparam int FILL_W  = 8;

  localparam int IDX_W   = $clog2(HIST_DEPTH);
  localparam int CNT_W   = $clog2(HIST_DEPTH + 1);
  localparam int NUM_W   = $clog2(HIST_DEPTH * MINUTES_PER_HOUR + 1);
  localparam int DSH_W   = NUM_W + DUTY_W;
  localparam int STEP_W  = $clog2(DUTY_W);

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(HIST_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/sliding_window_duty_and_trend.sv
`default_nettype none
// Heater duty and temperature trend over a sliding window of up to 239 samples.
// Each input beat is one history tick and produces exactly one result beat
// carrying the duty in minutes per hour, the newest minus oldest temperature
// and the window fill. A tick with an invalid sample goes straight to the
// output register and repeats the held values; a valid tick writes the new
// sample and reads the oldest one from the ring memory, then forms the trend
// and the duty numerator, runs the bit-serial duty divider and loads the
// output register. The next beat is taken once the previous result sits in
// the output register, so a stalled result holds at most one further tick
// in flight. The ring needs no clearing after reset: entries are only read
// once written, tracked by the fill count.
module sliding_window_duty_and_trend (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [14:0] temperature, [15] heater_active
  input  wire logic [swdt_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] temp_valid
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [5:0] work_minutes, [21:6] temp_change, [29:22] window_fill, [31:30] zero
  output logic      [swdt_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import swdt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   sum_r, sum_nxt;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  logic [TREND_W-1:0] trend_r, trend_nxt;

  logic [ENTRY_W-1:0] entry_r, entry_nxt;
  logic [NUM_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   div_r, div_nxt;
  logic [DUTY_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic               in_beat;
  logic [ENTRY_W-1:0] in_entry;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] old_entry;
  logic [CNT_W-1:0]   sum_inc;
  logic [CNT_W-1:0]   fill_inc;
  logic [IDX_W-1:0]   tail_adv;
  logic [DSH_W-1:0]   div_shift;
  logic               quo_bit;
  logic               out_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign in_entry  = in_tdata[ENTRY_W-1:0];

  // ring write of the new sample and read of the oldest one share the accept cycle
  swdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HIST_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (in_beat && in_tuser),
    .wr_addr (tail_r),
    .wr_data (in_entry),
    .rd_en   (in_beat && in_tuser),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  // on an empty ring the oldest entry is the one just written
  assign old_entry = (fill_r == '0) ? entry_r : rd_data;
  assign sum_inc   = sum_r + CNT_W'(entry_r[ENTRY_W-1]);
  assign fill_inc  = fill_r + CNT_W'(1);
  assign tail_adv  = next_index(tail_r);
  assign div_shift = DSH_W'(div_r) << step_r;
  assign quo_bit   = (DSH_W'(rem_r) >= div_shift);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    duty_nxt      = duty_r;
    trend_nxt     = trend_r;
    entry_nxt     = entry_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          entry_nxt = in_entry;
          state_nxt = in_tuser ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        trend_nxt = {entry_r[TEMP_W-1], entry_r[TEMP_W-1:0]}
                  - {old_entry[TEMP_W-1], old_entry[TEMP_W-1:0]};
        rem_nxt   = NUM_W'(sum_inc) * NUM_W'(MINUTES_PER_HOUR);
        div_nxt   = fill_inc;
        quo_nxt   = '0;
        step_nxt  = STEP_W'(DUTY_W - 1);
        tail_nxt  = tail_adv;
        // ring full: the oldest sample leaves the window
        if (tail_adv == head_r) begin
          sum_nxt  = sum_inc - CNT_W'(old_entry[ENTRY_W-1]);
          head_nxt = next_index(head_r);
          fill_nxt = fill_r;
        end else begin
          sum_nxt  = sum_inc;
          fill_nxt = fill_inc;
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (quo_bit) begin
          rem_nxt = rem_r - NUM_W'(div_shift);
        end
        quo_nxt  = {quo_r[DUTY_W-2:0], quo_bit};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          duty_nxt  = {quo_r[DUTY_W-2:0], quo_bit};
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({FILL_W'(fill_r), trend_r, duty_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      duty_r      <= '0;
      trend_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      duty_r      <= duty_nxt;
      trend_r     <= trend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r    <= entry_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    quo_r      <= quo_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

### rtl/swdt_ram.sv
`default_nettype none
module swdt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 240
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
